FILE: src/pli_pkg.sv
package pli_pkg;

	// Field widths fixed by the item format
	localparam int IDX_FIELD_W = 4;
	localparam int CNT_W       = 5;

	// Item action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Per-word status that rides down the pipe next to the data
	typedef struct packed {
		logic low;   // query at or below the first x
		logic high;  // query above the last x in use
		logic neg;   // slope of the segment is negative
	} flag_t;

endpackage

FILE: src/pli_table.sv
module pli_table #(
	parameter int MAX_POINTS  = 16,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [pli_pkg::CNT_W-1:0]          point_count,
	input  logic signed [VALUE_WIDTH-1:0]      query_s1,
	input  logic                               valid_s2,
	input  logic                               wr_en_s2,
	input  logic [pli_pkg::IDX_FIELD_W-1:0]    wr_idx_s2,
	input  logic signed [VALUE_WIDTH-1:0]      wr_x_s2,
	input  logic signed [VALUE_WIDTH-1:0]      wr_y_s2,
	output pli_pkg::flag_t                     flags_s2,
	output logic signed [VALUE_WIDTH-1:0]      x_lo,
	output logic signed [VALUE_WIDTH-1:0]      x_hi,
	output logic signed [VALUE_WIDTH-1:0]      y_lo,
	output logic signed [VALUE_WIDTH-1:0]      y_hi
);
	import pli_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	// Breakpoint lanes, one register pair per entry
	logic signed [W-1:0] x_mem [MAX_POINTS];
	logic signed [W-1:0] y_mem [MAX_POINTS];

	logic [MAX_POINTS-1:0] used;
	logic [MAX_POINTS-1:0] fwd;
	logic [MAX_POINTS:0]   stop;
	logic [MAX_POINTS:0]   hot;
	logic [MAX_POINTS:0]   hot_s2;
	flag_t                 flags_d;

	// Stage 1: compare every lane against the query, the write still in
	// stage 2 is forwarded so the lanes look committed in item order
	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			used[i] = (i == 0) || (32'(i) < 32'(point_count));
			fwd[i]  = wr_en_s2 && (32'(wr_idx_s2) == 32'(i));
			stop[i] = !used[i] || (query_s1 <= (fwd[i] ? wr_x_s2 : x_mem[i]));
		end
		stop[MAX_POINTS] = 1'b1;
		// lowest set bit marks the upper neighbor
		hot = stop & (~stop + (MAX_POINTS+1)'(1));
		flags_d.low  = hot[0];
		flags_d.high = hot[MAX_POINTS] | (|(hot[MAX_POINTS-1:0] & ~used));
		flags_d.neg  = 1'b0;
	end

	always_ff @(posedge clk) begin
		hot_s2   <= hot;
		flags_s2 <= flags_d;
	end

	// Table write commits at the end of stage 2
	always_ff @(posedge clk) begin
		if (wr_en_s2) begin
			x_mem[IW'(wr_idx_s2)] <= wr_x_s2;
			y_mem[IW'(wr_idx_s2)] <= wr_y_s2;
		end
	end

	// Stage 2: one-hot pick of the two neighbors
	always_comb begin
		x_lo = '0;
		x_hi = '0;
		y_lo = '0;
		y_hi = '0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (hot_s2[i]) begin
				x_hi = x_mem[i];
				y_hi = y_mem[i];
			end
			if (hot_s2[i+1]) begin
				x_lo = x_mem[i];
				y_lo = y_mem[i];
			end
		end
	end

	a_hot_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot(hot_s2))
		else $error("neighbor select is not one-hot");

endmodule

FILE: src/pli_div.sv
module pli_div #(
	parameter int W      = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2*W:0]      dividend,
	input  logic [W-1:0]      divisor,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [W:0]        quotient,
	output logic [SIDE_W-1:0] out_side
);
	// Quotient never exceeds W+1 bits, so the top W dividend bits start
	// as the remainder and one quotient bit is resolved per stage
	localparam int QW = W + 1;
	localparam int PW = 2 * W + 1;

	logic [QW-1:0]     valid_sk;
	logic [W-1:0]      rem_sk  [QW];
	logic [QW-1:0]     low_sk  [QW];
	logic [W-1:0]      div_sk  [QW];
	logic [SIDE_W-1:0] side_sk [QW];

	logic [W-1:0]      rem_src  [QW];
	logic [QW-1:0]     low_src  [QW];
	logic [W-1:0]      div_src  [QW];
	logic [SIDE_W-1:0] side_src [QW];
	logic [W:0]        trial    [QW];
	logic [QW-1:0]     take;

	// Restoring step for every stage
	always_comb begin
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				rem_src[k]  = dividend[PW-1:QW];
				low_src[k]  = dividend[QW-1:0];
				div_src[k]  = divisor;
				side_src[k] = in_side;
			end else begin
				rem_src[k]  = rem_sk[k-1];
				low_src[k]  = low_sk[k-1];
				div_src[k]  = div_sk[k-1];
				side_src[k] = side_sk[k-1];
			end
			trial[k] = {rem_src[k], low_src[k][QW-1]};
			take[k]  = trial[k] >= {1'b0, div_src[k]};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QW; k++) begin
			rem_sk[k]  <= take[k] ? W'(trial[k] - {1'b0, div_src[k]}) : trial[k][W-1:0];
			low_sk[k]  <= {low_src[k][QW-2:0], take[k]};
			div_sk[k]  <= div_src[k];
			side_sk[k] <= side_src[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk <= '0;
		end else begin
			valid_sk <= {valid_sk[QW-2:0], in_valid};
		end
	end

	assign out_valid = valid_sk[QW-1];
	assign quotient  = low_sk[QW-1];
	assign out_side  = side_sk[QW-1];

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> (divisor != '0))
		else $error("divider fed a zero divisor");

	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> (dividend[PW-1:QW] < divisor))
		else $error("quotient would overflow the stage count");

endmodule

FILE: src/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a table of up to MAX_POINTS
// breakpoint pairs, signed fixed point.
//
// Command channel: a word is taken at each rising edge with start high
// and busy low. busy stays low, so one word can be taken every cycle.
// action selects a table write (point_index, point_x, point_y) or a
// query (query_x). Every word, write or query, gives exactly one result.
// Result channel: done is high for one cycle with result_value,
// clamped_low and clamped_high; the receiver cannot hold it off.
// A word passes the command, table, difference and product stages,
// then the divider, which resolves one quotient bit per pipeline
// stage, and last the output register that drives done.
// Throughput is one word per cycle, writes and queries mixed freely.
// Config channel: cfg_valid/cfg_ready write point_count; cfg_ready is
// always high. Write it only while no word is in flight.
// Reset clears the pipeline and sets point_count to 1; table contents
// are undefined until written.
module piecewise_linear_interpolator #(
	parameter int MAX_POINTS  = 16,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic [pli_pkg::IDX_FIELD_W-1:0]  point_index,
	input  logic signed [VALUE_WIDTH-1:0]    point_x,
	input  logic signed [VALUE_WIDTH-1:0]    point_y,
	input  logic signed [VALUE_WIDTH-1:0]    query_x,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pli_pkg::CNT_W-1:0]        cfg_data,
	output logic                             done,
	output logic signed [VALUE_WIDTH-1:0]    result_value,
	output logic                             clamped_low,
	output logic                             clamped_high
);
	import pli_pkg::*;

	localparam int W      = VALUE_WIDTH;
	localparam int FL_W   = $bits(flag_t);
	localparam int SIDE_W = W + FL_W;

	// Config register
	logic [CNT_W-1:0] point_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			point_count_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// Stage 1: captured command word
	logic                   valid_s1;
	logic                   action_s1;
	logic [IDX_FIELD_W-1:0] idx_s1;
	logic signed [W-1:0]    px_s1, py_s1, qx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		action_s1 <= action;
		idx_s1    <= point_index;
		px_s1     <= point_x;
		py_s1     <= point_y;
		qx_s1     <= query_x;
	end

	// Stage 2: pending write and query, neighbors from the table
	logic                   valid_s2, query_s2, wr_en_s2;
	logic [IDX_FIELD_W-1:0] idx_s2;
	logic signed [W-1:0]    px_s2, py_s2, qx_s2;
	flag_t                  flags_s2;
	logic signed [W-1:0]    x_lo, x_hi, y_lo, y_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			wr_en_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			wr_en_s2 <= valid_s1 && (action_s1 == ACT_WRITE) &&
			            (32'(idx_s1) < 32'(MAX_POINTS));
		end
	end

	always_ff @(posedge clk) begin
		query_s2 <= (action_s1 == ACT_QUERY);
		idx_s2   <= idx_s1;
		px_s2    <= px_s1;
		py_s2    <= py_s1;
		qx_s2    <= qx_s1;
	end

	// only queries read the lanes, so only they carry a select
	pli_table #(
		.MAX_POINTS  (MAX_POINTS),
		.VALUE_WIDTH (W)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_count (point_count_q),
		.query_s1    (qx_s1),
		.valid_s2    (valid_s2 && query_s2),
		.wr_en_s2    (wr_en_s2),
		.wr_idx_s2   (idx_s2),
		.wr_x_s2     (px_s2),
		.wr_y_s2     (py_s2),
		.flags_s2    (flags_s2),
		.x_lo        (x_lo),
		.x_hi        (x_hi),
		.y_lo        (y_lo),
		.y_hi        (y_hi)
	);

	// Segment differences; clamps and writes get a zero step over span 1
	logic              interior;
	logic signed [W:0] dx_w, span_w, dy_w;

	always_comb begin
		interior = query_s2 && !flags_s2.low && !flags_s2.high;
		dx_w     = {qx_s2[W-1], qx_s2} - {x_lo[W-1], x_lo};
		span_w   = {x_hi[W-1], x_hi} - {x_lo[W-1], x_lo};
		dy_w     = {y_hi[W-1], y_hi} - {y_lo[W-1], y_lo};
	end

	// Stage 3
	logic                valid_s3;
	flag_t               flags_s3;
	logic signed [W-1:0] base_s3;
	logic [W-1:0]        dx_s3, span_s3;
	logic signed [W:0]   dy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		flags_s3.low  <= query_s2 && flags_s2.low;
		flags_s3.high <= query_s2 && flags_s2.high;
		flags_s3.neg  <= 1'b0;
		if (!query_s2) begin
			base_s3 <= '0;
		end else if (flags_s2.low) begin
			base_s3 <= y_hi;
		end else begin
			base_s3 <= y_lo;
		end
		dx_s3   <= interior ? dx_w[W-1:0] : '0;
		span_s3 <= interior ? span_w[W-1:0] : W'(1);
		dy_s3   <= interior ? dy_w : '0;
	end

	// Stage 4: magnitude times offset
	logic              neg_s3;
	logic [W:0]        mag_s3;
	logic [2*W:0]      prod;
	logic              valid_s4;
	logic [2*W:0]      prod_s4;
	logic [W-1:0]      span_s4;
	logic [SIDE_W-1:0] side_s4;

	always_comb begin
		neg_s3 = dy_s3[W];
		mag_s3 = neg_s3 ? (~dy_s3 + (W+1)'(1)) : dy_s3;
		prod   = dx_s3 * mag_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= prod;
		span_s4 <= span_s3;
		side_s4 <= {base_s3, flags_s3.low, flags_s3.high, neg_s3};
	end

	// Truncating divide, one quotient bit per stage
	logic              div_valid;
	logic [W:0]        quot;
	logic [SIDE_W-1:0] div_side;

	pli_div #(
		.W      (W),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.dividend  (prod_s4),
		.divisor   (span_s4),
		.in_side   (side_s4),
		.out_valid (div_valid),
		.quotient  (quot),
		.out_side  (div_side)
	);

	// Final add toward the upper neighbor
	logic signed [W-1:0] base_d;
	flag_t               flags_d;
	logic [W:0]          sum_d;

	always_comb begin
		base_d  = div_side[SIDE_W-1:FL_W];
		flags_d = flag_t'(div_side[FL_W-1:0]);
		sum_d   = flags_d.neg ? ({base_d[W-1], base_d} - quot)
		                      : ({base_d[W-1], base_d} + quot);
	end

	logic                done_q;
	logic signed [W-1:0] result_q;
	logic                low_q, high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= sum_d[W-1:0];
		low_q    <= flags_d.low;
		high_q   <= flags_d.high;
	end

	assign done         = done_q;
	assign result_value = result_q;
	assign clamped_low  = low_q;
	assign clamped_high = high_q;

	a_clamp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(clamped_low && clamped_high))
		else $error("both clamp flags set on one result");

endmodule

FILE: test/piecewise_linear_interpolator_tb.sv
module piecewise_linear_interpolator_tb;
	import pli_pkg::*;

	localparam int PTS         = 16;
	localparam int SETTLE      = 25;      // pipe depth plus margin
	localparam int CYCLE_LIMIT = 400000;
	localparam int TARGET      = 1450;

	typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN} op_kind_t;

	// One pending operation for the driver
	typedef struct {
		op_kind_t           kind;
		logic               act;
		logic [3:0]         idx;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] qx;
		logic [4:0]         cnt;
		int                 gap;
	} curve_op_t;

	typedef struct packed {
		logic [15:0] value;
		logic        low;
		logic        high;
	} interp_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic action = ACT_WRITE;
	logic [IDX_FIELD_W-1:0] point_index = '0;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic signed [15:0] query_x = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;
	logic done;
	logic signed [15:0] result_value;
	logic clamped_low;
	logic clamped_high;

	piecewise_linear_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.action(action), .point_index(point_index),
		.point_x(point_x), .point_y(point_y), .query_x(query_x),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .result_value(result_value),
		.clamped_low(clamped_low), .clamped_high(clamped_high)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted block state
	logic signed [15:0] tbl_x [PTS];
	logic signed [15:0] tbl_y [PTS];
	logic [4:0]         pred_count = 5'd1;

	curve_op_t   pending_ops[$];
	interp_res_t expected_results[$];
	int          mismatches = 0;
	int          word_total = 0;
	bit          gap_on = 1'b0;
	int          gen_x [PTS];   // x table as the generator last wrote it

	// Driver bookkeeping
	curve_op_t cur_op;
	bit        op_live = 1'b0;
	bit        launched = 1'b0;
	int        wait_left = 0;
	int        settle = 0;
	bit        stim_idle = 1'b0;

	// Apply one accepted word to the predicted table and return its result
	function automatic interp_res_t eval_word(input curve_op_t op);
		interp_res_t r;
		int n;
		int hi;
		longint q, xl, yl, yh, dx, span, dy, mag, quot, res;
		r = '0;
		if (op.act == ACT_WRITE) begin
			tbl_x[op.idx] = op.px;
			tbl_y[op.idx] = op.py;
		end else begin
			q = $signed(op.qx);
			n = (pred_count == 0) ? 1 : ((pred_count > PTS) ? PTS : pred_count);
			hi = 0;
			while (hi < n && q > $signed(tbl_x[hi]))
				hi++;
			if (hi == 0) begin
				r.value = tbl_y[0];
				r.low = 1'b1;
			end else if (hi == n) begin
				r.value = tbl_y[n-1];
				r.high = 1'b1;
			end else begin
				xl = $signed(tbl_x[hi-1]);
				yl = $signed(tbl_y[hi-1]);
				yh = $signed(tbl_y[hi]);
				dx = q - xl;
				span = $signed(tbl_x[hi]) - xl;
				dy = yh - yl;
				mag = (dy < 0) ? -dy : dy;
				quot = (dx * mag) / span;
				res = (dy < 0) ? yl - quot : yl + quot;
				r.value = res[15:0];
			end
		end
		return r;
	endfunction

	// Field values arrive as plain integers and are cut to the port widths
	task automatic add_word(input logic act, input int idx,
			input int px, input int py, input int qx);
		curve_op_t op;
		op.kind = OP_WORD;
		op.act = act;
		op.idx = 4'(idx);
		op.px = 16'(px);
		op.py = 16'(py);
		op.qx = 16'(qx);
		op.cnt = '0;
		op.gap = gap_on ? $urandom_range(0, 4) : 0;
		if (act == ACT_WRITE)
			gen_x[op.idx] = op.px;
		pending_ops.push_back(op);
		word_total++;
	endtask

	task automatic add_ctrl(input op_kind_t kind, input int cnt);
		curve_op_t op;
		op.kind = kind;
		op.act = ACT_WRITE;
		op.idx = '0;
		op.px = '0;
		op.py = '0;
		op.qx = '0;
		op.cnt = 5'(cnt);
		op.gap = gap_on ? $urandom_range(0, 4) : 0;
		pending_ops.push_back(op);
	endtask

	// Directed words, then random phases of table load plus queries
	initial begin
		int cfg_val, n, w, span, base, nq, s, lo, hi, q;
		int xs[$];
		bit ascend;

		// single pair in use (reset count), extreme pair
		add_word(ACT_WRITE, 0, 16'h8000, 16'h8000, $urandom);
		add_word(ACT_QUERY, $urandom, $urandom, $urandom, 16'h8000);
		add_word(ACT_QUERY, $urandom, $urandom, $urandom, 16'h7fff);
		// full table spanning the whole x range, alternating extreme y
		for (int i = 0; i < PTS; i++)
			add_word(ACT_WRITE, i, -32768 + i * 4369, i[0] ? 16'h7fff : 16'h8000,
				$urandom);
		add_ctrl(OP_DRAIN, 0);
		add_ctrl(OP_CFG, 16);
		add_word(ACT_QUERY, $urandom, $urandom, $urandom, 16'h8000);
		add_word(ACT_QUERY, $urandom, $urandom, $urandom, 16'h7fff);
		add_word(ACT_QUERY, $urandom, $urandom, $urandom, -32768 + 3 * 4369 + 2000);
		add_word(ACT_QUERY, $urandom, $urandom, $urandom, 16'h0000);

		while (word_total < TARGET) begin
			case ($urandom_range(0, 9))
				0: cfg_val = 0;
				1: cfg_val = 1;
				2: cfg_val = 16;
				3: cfg_val = $urandom_range(17, 31);
				default: cfg_val = $urandom_range(2, 15);
			endcase
			n = (cfg_val == 0) ? 1 : ((cfg_val > PTS) ? PTS : cfg_val);
			gap_on = $urandom_range(0, 2) != 0;
			add_ctrl(OP_DRAIN, 0);
			add_ctrl(OP_CFG, cfg_val);

			// x values over a span of random width; now and then left unsorted
			w = $urandom_range(1, 16);
			span = (1 << w) - 1;
			base = -32768 + $urandom_range(0, 65535 - span);
			ascend = $urandom_range(0, 7) != 0;
			xs.delete();
			for (int i = 0; i < n; i++)
				xs.push_back(base + $urandom_range(0, span));
			if (ascend)
				xs.sort();
			for (int i = 0; i < n; i++)
				add_word(ACT_WRITE, i, xs[i], $urandom, $urandom);

			nq = $urandom_range(20, 60);
			for (int k = 0; k < nq; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					add_word(ACT_WRITE, $urandom, $urandom, $urandom, $urandom);
				end else begin
					case ($urandom_range(0, 9)) inside
						[0:4]: begin
							s = (n > 1) ? $urandom_range(0, n - 2) : 0;
							lo = gen_x[s];
							hi = (n > 1) ? gen_x[s+1] : gen_x[s];
							q = (lo < hi) ? lo + $urandom_range(0, hi - lo) : lo;
						end
						[5:6]: q = gen_x[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
						default: q = $urandom;
					endcase
					add_word(ACT_QUERY, $urandom, $urandom, $urandom, q);
				end
			end
		end
	end

	// Reset once at start
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: walks the pending list, one word or config write at a time
	always @(posedge clk) begin
		logic go_start, go_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			go_start = start;
			go_cfg = cfg_valid;
			if (start && !busy) begin
				expected_results.push_back(eval_word(cur_op));
				go_start = 1'b0;
				op_live = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				pred_count = cfg_data;
				go_cfg = 1'b0;
				op_live = 1'b0;
			end
			// drain: hold off until every result is back, then let the pipe settle
			if (op_live && cur_op.kind == OP_DRAIN && expected_results.size() == 0) begin
				if (settle == 0)
					op_live = 1'b0;
				else
					settle--;
			end
			if (!op_live && pending_ops.size() > 0) begin
				cur_op = pending_ops.pop_front();
				op_live = 1'b1;
				launched = 1'b0;
				wait_left = cur_op.gap;
				settle = SETTLE;
			end
			if (op_live && !launched && cur_op.kind != OP_DRAIN) begin
				if (wait_left > 0) begin
					wait_left--;
				end else begin
					launched = 1'b1;
					if (cur_op.kind == OP_WORD) begin
						go_start = 1'b1;
						action <= cur_op.act;
						point_index <= cur_op.idx;
						point_x <= cur_op.px;
						point_y <= cur_op.py;
						query_x <= cur_op.qx;
					end else begin
						go_cfg = 1'b1;
						cfg_data <= cur_op.cnt;
					end
				end
			end
			start <= go_start;
			cfg_valid <= go_cfg;
			stim_idle <= !op_live && pending_ops.size() == 0;
		end
	end

	// Monitor: each strobed result against the oldest prediction
	always @(posedge clk) begin
		interp_res_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: value %0d low %0b high %0b",
						result_value, clamped_low, clamped_high);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (result_value !== want.value || clamped_low !== want.low ||
						clamped_high !== want.high) begin
					if (mismatches < 10)
						$display("mismatch: want value %0d low %0b high %0b, got %0d %0b %0b",
							$signed(want.value), want.low, want.high,
							result_value, clamped_low, clamped_high);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// End of run
	initial begin
		wait (stim_idle);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
